### hw/rtl/ramr_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Shared widths, operation codes and the queue entry type.
// ----------------------------------------------------------------------------
package ramr_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int FUNC_BITS    = 2;
    localparam int NUM_OUT_BITS = 33;
    localparam int DEN_OUT_BITS = 31;
    // Raw magnitudes fit in 2*OPERAND_BITS+1 bits (a sum of two products).
    localparam int MAG_BITS     = 2 * OPERAND_BITS + 1;
    localparam int CNT_BITS     = $clog2(MAG_BITS + 1);

    localparam logic [FUNC_BITS-1:0] FUNC_NORMALIZE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ADD       = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_MUL       = 2'd2;
    // The unused selector value behaves as multiply.
    localparam logic [FUNC_BITS-1:0] FUNC_SPARE     = 2'd3;

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic                zero_den;
        logic                neg;
        logic [MAG_BITS-1:0] nmag;
        logic [MAG_BITS-1:0] dmag;
    } t_job;

endpackage

### hw/rtl/ramr_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic channels
// Valid/ready interfaces for operand items and result items.
// ----------------------------------------------------------------------------
interface ramr_in_if;
    import ramr_pkg::*;
    logic                           valid;
    logic                           ready;
    logic [FUNC_BITS-1:0]           func;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic signed [OPERAND_BITS-1:0] a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic signed [OPERAND_BITS-1:0] b_den;
    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ramr_out_if;
    import ramr_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [NUM_OUT_BITS-1:0] res_num;
    logic [DEN_OUT_BITS-1:0]        res_den;
    logic                           zero_den_error;
    modport source (output valid, res_num, res_den, zero_den_error, input ready);
    modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

### hw/rtl/ramr_front.sv
// ----------------------------------------------------------------------------
// Rational arithmetic front end
// Accepts an item, forms raw numerator and denominator magnitudes in two
// registered steps (products, then sum), and classifies zero denominators.
// ----------------------------------------------------------------------------
module ramr_front
    import ramr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ramr_in_if.sink      in_ch,
    output logic         o_job_valid,
    input  logic         i_job_ready,
    output t_job         o_job
);

    localparam int PB = 2 * OPERAND_BITS;

    logic                  r_v1, r_v2;
    logic [FUNC_BITS-1:0]  r_func;
    logic signed [PB-1:0]  r_p0, r_p1, r_pd;
    logic signed [OPERAND_BITS-1:0] r_an, r_ad;
    t_job                  r_job;
    logic signed [MAG_BITS-1:0] w_rn, w_rd;
    logic                  w_adv2, w_adv1;
    t_job                  n_job;

    assign w_adv2 = !r_v2 || i_job_ready;
    assign w_adv1 = !r_v1 || w_adv2;
    assign in_ch.ready = w_adv1;

    always_comb begin
        if (r_func == FUNC_NORMALIZE) begin
            w_rn = MAG_BITS'(r_an);
            w_rd = MAG_BITS'(r_ad);
        end else if (r_func == FUNC_ADD) begin
            w_rn = MAG_BITS'(r_p0) + MAG_BITS'(r_p1);
            w_rd = MAG_BITS'(r_pd);
        end else begin
            w_rn = MAG_BITS'(r_p0);
            w_rd = MAG_BITS'(r_pd);
        end
        n_job.zero_den = (w_rd == '0);
        n_job.neg      = w_rn[MAG_BITS-1] ^ w_rd[MAG_BITS-1];
        n_job.nmag     = w_rn[MAG_BITS-1] ? MAG_BITS'(-w_rn) : MAG_BITS'(w_rn);
        n_job.dmag     = w_rd[MAG_BITS-1] ? MAG_BITS'(-w_rd) : MAG_BITS'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= in_ch.valid;
            if (w_adv2) r_v2 <= r_v1;
        end
        if (w_adv1 && in_ch.valid) begin
            r_func <= in_ch.func;
            r_an   <= in_ch.a_num;
            r_ad   <= in_ch.a_den;
            // Multiply uses a_num*b_num; add uses a_num*b_den + a_den*b_num.
            r_p0 <= (in_ch.func == FUNC_ADD) ? PB'(in_ch.a_num * in_ch.b_den)
                                             : PB'(in_ch.a_num * in_ch.b_num);
            r_p1 <= PB'(in_ch.a_den * in_ch.b_num);
            r_pd <= PB'(in_ch.a_den * in_ch.b_den);
        end
        if (w_adv2 && r_v1) r_job <= n_job;
    end

    assign o_job_valid = r_v2;
    assign o_job       = r_job;

endmodule

### hw/rtl/ramr_queue.sv
// ----------------------------------------------------------------------------
// Rational arithmetic job queue
// Two-entry queue that decouples the front end from the reducer.
// ----------------------------------------------------------------------------
module ramr_queue
    import ramr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_job,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_job o_rd_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
        if (w_wr) r_mem[r_wp] <= i_wr_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_wr)
        else $error("queue written while full");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_valid && !i_rd_ready |=> o_rd_valid)
        else $error("queue entry lost while stalled");

endmodule

### hw/rtl/ramr_back.sv
// ----------------------------------------------------------------------------
// Rational arithmetic reducer
// Euclid's gcd and two divisions by the gcd on one shared restoring
// divider, one quotient bit per cycle, then sign fix-up into a result reg.
// ----------------------------------------------------------------------------
module ramr_back
    import ramr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    ramr_out_if.source out_ch
);

    typedef enum logic [2:0] {
        S_IDLE, S_GCD, S_DIVN, S_DIVD, S_DONE
    } t_state;

    t_state              r_state;
    logic [MAG_BITS-1:0] r_x, r_y;       // gcd operands
    logic [MAG_BITS-1:0] r_nm, r_dm, r_g;
    logic                r_neg;
    logic                r_zd;
    logic [MAG_BITS-1:0] r_dvd, r_quo, r_rem;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_out_v;
    logic signed [NUM_OUT_BITS-1:0] r_onum;
    logic [DEN_OUT_BITS-1:0]        r_oden;
    logic                r_oerr;

    logic [MAG_BITS:0]   w_trial;
    logic [MAG_BITS-1:0] w_shift, w_rem, w_quo, w_div;

    assign w_div   = (r_state == S_GCD) ? r_y : r_g;
    assign w_shift = {r_rem[MAG_BITS-2:0], r_dvd[MAG_BITS-1]};
    assign w_trial = {1'b0, w_shift} - {1'b0, w_div};
    assign w_rem   = w_trial[MAG_BITS] ? w_shift : w_trial[MAG_BITS-1:0];
    assign w_quo   = {r_quo[MAG_BITS-2:0], !w_trial[MAG_BITS]};

    assign o_job_ready = (r_state == S_IDLE);
    assign out_ch.valid          = r_out_v;
    assign out_ch.res_num        = r_onum;
    assign out_ch.res_den        = r_oden;
    assign out_ch.zero_den_error = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            // The result register is refilled only in S_DONE.
            if (out_ch.ready && r_state != S_DONE) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_nm  <= i_job.nmag;
                        r_dm  <= i_job.dmag;
                        r_neg <= i_job.neg && (i_job.nmag != '0);
                        r_x   <= i_job.nmag;
                        r_y   <= i_job.dmag;
                        r_dvd <= i_job.nmag;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= '0;
                        r_zd  <= i_job.zero_den;
                        r_state <= i_job.zero_den ? S_DONE : S_GCD;
                    end
                end
                S_GCD: begin
                    // One bit of x mod y per cycle; on a finished remainder
                    // the pair rotates, and a zero y leaves the gcd in x.
                    if (r_y == '0) begin
                        r_g   <= r_x;
                        r_dvd <= r_nm;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= '0;
                        r_state <= S_DIVN;
                    end else if (r_cnt == CNT_BITS'(MAG_BITS - 1)) begin
                        r_x   <= r_y;
                        r_y   <= w_rem;
                        r_dvd <= r_y;
                        r_rem <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_rem <= w_rem;
                        r_dvd <= r_dvd << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (r_cnt == CNT_BITS'(MAG_BITS - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_quo <= '0;
                        if (r_state == S_DIVN) begin
                            r_nm  <= w_quo;
                            r_dvd <= r_dm;
                            r_state <= S_DIVD;
                        end else begin
                            r_dm  <= w_quo;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_rem <= w_rem;
                        r_quo <= w_quo;
                        r_dvd <= r_dvd << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_v || out_ch.ready) begin
                        r_out_v <= 1'b1;
                        r_oerr  <= r_zd;
                        r_onum  <= r_zd ? '0 : (r_neg ? NUM_OUT_BITS'(-r_nm)
                                                      : NUM_OUT_BITS'(r_nm));
                        r_oden  <= r_zd ? '0 : DEN_OUT_BITS'(r_dm);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_oerr |-> r_oden == '0 && r_onum == '0)
        else $error("error result not 0/0");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_oerr |-> r_oden != '0)
        else $error("zero denominator without error");
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVN |-> r_g != '0)
        else $error("zero gcd");

endmodule

### hw/rtl/rational_add_mul_reduce.sv
// ----------------------------------------------------------------------------
// Rational add/multiply with gcd reduction
// Top level: front end, job queue and reducer.
// ----------------------------------------------------------------------------
// Usage: operand items (func, a_num/a_den, b_num/b_den) enter on in_ch with
// valid/ready; each gives exactly one result item on out_ch with the reduced
// numerator, a positive denominator and an error flag (0/0 on a zero
// denominator). The front end registers products, then sum and magnitudes,
// and hands jobs through a two-entry queue to the reducer.
// The reducer runs Euclid's loop on one bit-serial divider, then divides
// numerator and denominator by the gcd on that shared divider; it takes a
// new job only when idle, so one item finishes before the next starts. A
// zero denominator skips the divider. Reset (synchronous, active low)
// empties the pipeline and queue. When the receiver stalls, the result
// register holds; the queue and front end keep accepting until they fill,
// then ready drops.
// ----------------------------------------------------------------------------
module rational_add_mul_reduce
    import ramr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ramr_in_if.sink   in_ch,
    ramr_out_if.source out_ch
);

    logic f_valid, f_ready, b_valid, b_ready;
    t_job f_job, b_job;

    ramr_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    ramr_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_job(f_job),
        .o_rd_valid(b_valid), .i_rd_ready(b_ready), .o_rd_job(b_job)
    );

    ramr_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(b_valid), .o_job_ready(b_ready), .i_job(b_job), .out_ch
    );

endmodule
